[hw/rtl/slab_mesh_facet_generator_assert.svh]
// Assertion macros for the slab mesh facet generator.
// Used by the top level only; no other dependencies.
`ifndef SLAB_MESH_FACET_GENERATOR_ASSERT_SVH
`define SLAB_MESH_FACET_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SMFG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smfg: implication check failed");

// Next-cycle implication, disabled while reset is held
`define SMFG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smfg: next-cycle check failed");

`endif

[hw/rtl/smfg_pkg.sv]
// Shared types, constants and the triangle table of the slab mesh facet generator.
// No dependencies.
package smfg_pkg;

    // Field widths
    localparam int ROW_W   = 8;
    localparam int CNT_W   = 9;
    localparam int VTX_W   = 18;
    localparam int FACET_W = 19;

    // Grid limits
    localparam int MAX_CELLS_Y = 256;
    localparam int MAX_CELLS_Z = 256;

    // Vertex slots of one cell: back face A..D, then front face A..D
    localparam int NUM_VTX = 8;
    localparam int VSEL_W  = 3;
    localparam logic [VSEL_W-1:0] V_BA = 3'd0;
    localparam logic [VSEL_W-1:0] V_BB = 3'd1;
    localparam logic [VSEL_W-1:0] V_BC = 3'd2;
    localparam logic [VSEL_W-1:0] V_BD = 3'd3;
    localparam logic [VSEL_W-1:0] V_FA = 3'd4;
    localparam logic [VSEL_W-1:0] V_FB = 3'd5;
    localparam logic [VSEL_W-1:0] V_FC = 3'd6;
    localparam logic [VSEL_W-1:0] V_FD = 3'd7;

    // Triangle slots of one cell
    localparam int NUM_SLOTS = 12;
    localparam int SLOT_W    = 4;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    typedef logic [NUM_VTX-1:0][VTX_W-1:0] t_vtx_arr;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_CELLS_Y = 1'b0,
        CFG_CELLS_Z = 1'b1
    } t_cfg_idx;

    // Top level sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_state;

    // Steps of the shared multiply-add unit
    typedef enum logic [3:0] {
        VG_BA,
        VG_PLANE,
        VG_BB,
        VG_BC,
        VG_BD,
        VG_FA,
        VG_FB,
        VG_FC,
        VG_FD
    } t_vg_step;

    typedef struct packed {
        logic [VSEL_W-1:0] a;
        logic [VSEL_W-1:0] b;
        logic [VSEL_W-1:0] c;
        logic              is_tile;
        logic              face;
        logic              half;
    } t_tri;

    // Tiles first, then wall pairs: first row, last row, first column, last column
    function automatic t_tri tri_of(input logic [SLOT_W-1:0] slot);
        t_tri t;
        t = '{a: V_BA, b: V_BA, c: V_BA, is_tile: 1'b0, face: 1'b0, half: 1'b0};
        unique case (slot)
            4'd0:  t = '{a: V_BA, b: V_BC, c: V_BB, is_tile: 1'b1, face: 1'b0, half: 1'b0};
            4'd1:  t = '{a: V_BA, b: V_BD, c: V_BC, is_tile: 1'b1, face: 1'b0, half: 1'b1};
            4'd2:  t = '{a: V_FA, b: V_FB, c: V_FC, is_tile: 1'b1, face: 1'b1, half: 1'b0};
            4'd3:  t = '{a: V_FA, b: V_FC, c: V_FD, is_tile: 1'b1, face: 1'b1, half: 1'b1};
            4'd4:  t.a = V_BA;
            4'd5:  t = '{a: V_BA, b: V_FD, c: V_BD, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            4'd6:  t = '{a: V_BB, b: V_BC, c: V_FC, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            4'd7:  t = '{a: V_BB, b: V_FC, c: V_FB, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            4'd8:  t = '{a: V_BA, b: V_BB, c: V_FB, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            4'd9:  t = '{a: V_BA, b: V_FB, c: V_FA, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            4'd10: t = '{a: V_BD, b: V_FD, c: V_FC, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            4'd11: t = '{a: V_BD, b: V_FC, c: V_BC, is_tile: 1'b0, face: 1'b0, half: 1'b0};
            default: t = '{a: V_BA, b: V_BA, c: V_BA, is_tile: 1'b0, face: 1'b0, half: 1'b0};
        endcase
        // first-row wall, first triangle
        if (slot == 4'd4) begin
            t = '{a: V_BA, b: V_FA, c: V_FD, is_tile: 1'b0, face: 1'b0, half: 1'b0};
        end
        return t;
    endfunction

endpackage

[hw/rtl/smfg_vgen.sv]
// Vertex index generator: one shared multiply-add unit stepped by a small counter.
// Depends on smfg_pkg.
module smfg_vgen (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [smfg_pkg::ROW_W-1:0]      i_row,
    input  logic [smfg_pkg::ROW_W-1:0]      i_col,
    input  logic [smfg_pkg::CNT_W-1:0]      i_nyp1,
    input  logic [smfg_pkg::CNT_W-1:0]      i_nzp1,
    output logic                            o_done,
    output smfg_pkg::t_vtx_arr              o_vtx
);

    localparam int PROD_W = smfg_pkg::CNT_W + smfg_pkg::VTX_W;

    logic                            r_busy;
    smfg_pkg::t_vg_step              r_step;
    smfg_pkg::t_vtx_arr              r_vtx;
    logic [smfg_pkg::VTX_W-1:0]      r_plane;

    logic [smfg_pkg::CNT_W-1:0]      w_x;
    logic [smfg_pkg::VTX_W-1:0]      w_y;
    logic [smfg_pkg::VTX_W-1:0]      w_z;
    logic [PROD_W-1:0]               w_prod;
    logic [smfg_pkg::VTX_W-1:0]      w_sum;
    logic [smfg_pkg::VSEL_W-1:0]     w_dst;
    logic                            w_to_plane;

    // Pick operands of x*y+z for the current step
    always_comb begin
        w_x        = smfg_pkg::CNT_W'(1);
        w_y        = smfg_pkg::VTX_W'(1);
        w_z        = '0;
        w_dst      = smfg_pkg::V_BA;
        w_to_plane = 1'b0;
        unique case (r_step)
            smfg_pkg::VG_BA: begin
                w_x   = {1'b0, i_row};
                w_y   = smfg_pkg::VTX_W'(i_nzp1);
                w_z   = smfg_pkg::VTX_W'(i_col);
                w_dst = smfg_pkg::V_BA;
            end
            smfg_pkg::VG_PLANE: begin
                w_x        = i_nyp1;
                w_y        = smfg_pkg::VTX_W'(i_nzp1);
                w_to_plane = 1'b1;
            end
            smfg_pkg::VG_BB: begin
                w_y   = smfg_pkg::VTX_W'(i_nzp1);
                w_z   = r_vtx[smfg_pkg::V_BA];
                w_dst = smfg_pkg::V_BB;
            end
            smfg_pkg::VG_BC: begin
                w_z   = r_vtx[smfg_pkg::V_BB];
                w_dst = smfg_pkg::V_BC;
            end
            smfg_pkg::VG_BD: begin
                w_z   = r_vtx[smfg_pkg::V_BA];
                w_dst = smfg_pkg::V_BD;
            end
            smfg_pkg::VG_FA: begin
                w_y   = r_plane;
                w_z   = r_vtx[smfg_pkg::V_BA];
                w_dst = smfg_pkg::V_FA;
            end
            smfg_pkg::VG_FB: begin
                w_y   = r_plane;
                w_z   = r_vtx[smfg_pkg::V_BB];
                w_dst = smfg_pkg::V_FB;
            end
            smfg_pkg::VG_FC: begin
                w_y   = r_plane;
                w_z   = r_vtx[smfg_pkg::V_BC];
                w_dst = smfg_pkg::V_FC;
            end
            smfg_pkg::VG_FD: begin
                w_y   = r_plane;
                w_z   = r_vtx[smfg_pkg::V_BD];
                w_dst = smfg_pkg::V_FD;
            end
            default: begin
                w_dst = smfg_pkg::V_BA;
            end
        endcase
    end

    // Shared multiply-add, truncated to the vertex width
    assign w_prod = PROD_W'(w_x) * PROD_W'(w_y);
    assign w_sum  = w_prod[smfg_pkg::VTX_W-1:0] + w_z;

    assign o_done = r_busy && (r_step == smfg_pkg::VG_FD);
    assign o_vtx  = r_vtx;

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= smfg_pkg::VG_BA;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= smfg_pkg::VG_BA;
        end else if (r_busy) begin
            if (r_step == smfg_pkg::VG_FD) begin
                r_busy <= 1'b0;
                r_step <= smfg_pkg::VG_BA;
            end else begin
                r_step <= smfg_pkg::t_vg_step'(4'(r_step) + 4'd1);
            end
        end
    end

    // Store each step's result
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (w_to_plane) begin
                r_plane <= w_sum;
            end else begin
                r_vtx[w_dst] <= w_sum;
            end
        end
    end

endmodule

[hw/rtl/slab_mesh_facet_generator.sv]
// Slab mesh facet generator: emits the triangles of one grid cell per request.
// Each accepted cell inside the grid first runs the vertex arithmetic on the shared
// multiply-add unit, then steps the triangle slots, skipping slots without a triangle
// (at most one result per cycle, held while the output stalls). A new cell request is
// taken only after the last slot; a cell outside the grid is taken and emits nothing.
// Reset (synchronous, active low): cell counts to 1, facet counter to 0, channels idle.
`include "slab_mesh_facet_generator_assert.svh"
// Depends on smfg_pkg, smfg_vgen and slab_mesh_facet_generator_assert.svh.
module slab_mesh_facet_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // Cell requests
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] cell_row, [15:8] cell_col
    input  logic [0:0]  i_s_tuser,   // [0] first_cell
    // Triangle results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [18:0] facet_number, [36:19] vertex_a,
                                     // [54:37] vertex_b, [72:55] vertex_c, rest zero
    output logic [2:0]  o_m_tuser,   // [0] is_tile, [1] tile_face, [2] tile_half
    output logic        o_m_tlast    // last_of_cell
);

    localparam int RW = smfg_pkg::ROW_W;
    localparam int CW = smfg_pkg::CNT_W;
    localparam int VW = smfg_pkg::VTX_W;
    localparam int FW = smfg_pkg::FACET_W;
    localparam int NS = smfg_pkg::NUM_SLOTS;

    smfg_pkg::t_state              r_state;
    smfg_pkg::t_state              n_state;

    logic [CW-1:0]                 r_ny;
    logic [CW-1:0]                 r_nz;
    logic [RW-1:0]                 r_row;
    logic [RW-1:0]                 r_col;
    logic [NS-1:0]                 r_mask;
    logic [smfg_pkg::SLOT_W-1:0]   r_slot;
    logic [FW-1:0]                 r_facet;

    logic                          r_out_valid;
    logic [FW-1:0]                 r_out_facet;
    logic [VW-1:0]                 r_out_a;
    logic [VW-1:0]                 r_out_b;
    logic [VW-1:0]                 r_out_c;
    logic                          r_out_tile;
    logic                          r_out_face;
    logic                          r_out_half;
    logic                          r_out_last;

    logic [RW-1:0]                 w_in_row;
    logic [RW-1:0]                 w_in_col;
    logic                          w_in_first;
    logic                          w_accept;
    logic                          w_in_grid;
    logic [CW-1:0]                 w_cfg_clamped;
    logic [CW-1:0]                 w_nyp1;
    logic [CW-1:0]                 w_nzp1;
    logic                          w_vg_done;
    smfg_pkg::t_vtx_arr            w_vtx;
    smfg_pkg::t_tri                w_tri;
    logic [NS-1:0]                 w_after;
    logic                          w_slot_en;
    logic                          w_out_free;
    logic                          w_load;
    logic                          w_adv;

    // Unpack the request
    assign w_in_row   = i_s_tdata[RW-1:0];
    assign w_in_col   = i_s_tdata[2*RW-1:RW];
    assign w_in_first = i_s_tuser[0];

    assign o_s_tready  = (r_state == smfg_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_in_grid   = ({1'b0, w_in_row} < r_ny) && ({1'b0, w_in_col} < r_nz);

    // Clamp a written cell count into 1..MAX
    always_comb begin
        priority if (i_cfg_data == '0) begin
            w_cfg_clamped = CW'(1);
        end else if (i_cfg_data > CW'(smfg_pkg::MAX_CELLS_Y)) begin
            w_cfg_clamped = CW'(smfg_pkg::MAX_CELLS_Y);
        end else begin
            w_cfg_clamped = i_cfg_data;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ny <= CW'(1);
            r_nz <= CW'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (smfg_pkg::t_cfg_idx'(i_cfg_index))
                smfg_pkg::CFG_CELLS_Y: r_ny <= w_cfg_clamped;
                smfg_pkg::CFG_CELLS_Z: begin
                    if (i_cfg_data > CW'(smfg_pkg::MAX_CELLS_Z)) begin
                        r_nz <= CW'(smfg_pkg::MAX_CELLS_Z);
                    end else begin
                        r_nz <= w_cfg_clamped;
                    end
                end
                default: r_ny <= r_ny;
            endcase
        end
    end

    assign w_nyp1 = r_ny + CW'(1);
    assign w_nzp1 = r_nz + CW'(1);

    smfg_vgen u_vgen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_in_grid),
        .i_row   (r_row),
        .i_col   (r_col),
        .i_nyp1  (w_nyp1),
        .i_nzp1  (w_nzp1),
        .o_done  (w_vg_done),
        .o_vtx   (w_vtx)
    );

    // Current slot lookup and last-of-cell detection
    assign w_tri      = smfg_pkg::tri_of(r_slot);
    assign w_slot_en  = r_mask[r_slot];
    assign w_after    = r_mask >> r_slot;
    assign w_out_free = !r_out_valid || i_m_tready;

    // Next state and slot stepping
    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_adv   = 1'b0;
        unique case (r_state)
            smfg_pkg::ST_IDLE: begin
                if (w_accept && w_in_grid) begin
                    n_state = smfg_pkg::ST_CALC;
                end
            end
            smfg_pkg::ST_CALC: begin
                if (w_vg_done) begin
                    n_state = smfg_pkg::ST_EMIT;
                end
            end
            smfg_pkg::ST_EMIT: begin
                w_load = w_slot_en && w_out_free;
                w_adv  = !w_slot_en || w_out_free;
                if (w_adv && (r_slot == smfg_pkg::SLOT_LAST)) begin
                    n_state = smfg_pkg::ST_IDLE;
                end
            end
            default: n_state = smfg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smfg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the cell and its wall mask, step the slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_mask <= '0;
        end else if (w_accept) begin
            r_slot   <= '0;
            r_mask   <= {{2{{1'b0, w_in_col} == r_nz - CW'(1)}},
                         {2{w_in_col == '0}},
                         {2{{1'b0, w_in_row} == r_ny - CW'(1)}},
                         {2{w_in_row == '0}},
                         4'b1111};
        end else if (w_adv) begin
            r_slot <= r_slot + smfg_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row <= w_in_row;
            r_col <= w_in_col;
        end
    end

    // Facet counter: clear on first cell, advance per emitted triangle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_facet <= '0;
        end else if (w_accept && w_in_first) begin
            r_facet <= '0;
        end else if (w_load) begin
            r_facet <= r_facet + FW'(1);
        end
    end

    // Output register: hold until taken, load the next triangle when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_facet <= r_facet;
            r_out_a     <= w_vtx[w_tri.a];
            r_out_b     <= w_vtx[w_tri.b];
            r_out_c     <= w_vtx[w_tri.c];
            r_out_tile  <= w_tri.is_tile;
            r_out_face  <= w_tri.face;
            r_out_half  <= w_tri.half;
            r_out_last  <= (w_after[NS-1:1] == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_c, r_out_b, r_out_a, r_out_facet};
    assign o_m_tuser  = {r_out_half, r_out_face, r_out_tile};
    assign o_m_tlast  = r_out_last;

    // Checks
    `SMFG_ASSERT_IMP(a_done_in_calc, i_clk, i_rst_n, w_vg_done, r_state == smfg_pkg::ST_CALC)
    `SMFG_ASSERT_NXT(a_emit_from_slot0, i_clk, i_rst_n, w_vg_done, (r_state == smfg_pkg::ST_EMIT) && (r_slot == '0))
    `SMFG_ASSERT_IMP(a_more_follow, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, r_state == smfg_pkg::ST_EMIT)
    `SMFG_ASSERT_IMP(a_wall_flags, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], !o_m_tuser[1] && !o_m_tuser[2])

endmodule

[tb/testbench.sv]
// Self-checking testbench for slab_mesh_facet_generator: random and directed grid cells.
// Predicts every triangle of each accepted cell request and checks the result stream.
// Depends on smfg_pkg and the slab_mesh_facet_generator RTL.
module testbench;
    import smfg_pkg::*;

    // One cell request as queued for the driver
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             first;
    } cell_req_t;

    // One expected triangle
    typedef struct packed {
        logic [FACET_W-1:0] facet;
        logic [VTX_W-1:0]   va;
        logic [VTX_W-1:0]   vb;
        logic [VTX_W-1:0]   vc;
        logic               tile;
        logic               face;
        logic               half;
        logic               last;
    } triangle_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = CFG_CELLS_Y;
    logic [8:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [79:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    cell_req_t          cells_pending[$];
    triangle_t          triangles_due[$];
    logic [CNT_W-1:0]   model_cells_y = 9'd1;
    logic [CNT_W-1:0]   model_cells_z = 9'd1;
    logic [FACET_W-1:0] facet_next = '0;
    int                 cell_left;
    int                 err_count = 0;
    int                 cells_sent = 0;
    int                 triangles_seen = 0;
    int                 grid_settings = 0;
    logic               no_gaps = 1'b0;

    slab_mesh_facet_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // Clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Clamp a cell count register to the usable range
    function automatic int grid_count(input logic [CNT_W-1:0] v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [VTX_W-1:0] vertex_index(input int face, input int r,
                                                      input int c, input int ny,
                                                      input int nz);
        return VTX_W'(face * (ny + 1) * (nz + 1) + r * (nz + 1) + c);
    endfunction

    // Append one triangle and advance the facet number
    task automatic emit_expected(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b,
                                 input logic [VTX_W-1:0] c, input logic tile,
                                 input logic face, input logic half);
        triangle_t t;
        cell_left--;
        t = '{facet: facet_next, va: a, vb: b, vc: c, tile: tile, face: face,
              half: half, last: (cell_left == 0)};
        triangles_due.push_back(t);
        facet_next = facet_next + 1'b1;
    endtask

    // Work out all triangles of one accepted cell request
    task automatic predict_cell_triangles(input logic [ROW_W-1:0] row,
                                          input logic [ROW_W-1:0] col,
                                          input logic first);
        int ny;
        int nz;
        logic [VTX_W-1:0] v[NUM_VTX];
        ny = grid_count(model_cells_y, MAX_CELLS_Y);
        nz = grid_count(model_cells_z, MAX_CELLS_Z);
        if (first) facet_next = '0;
        if (row >= ny || col >= nz) return;
        // corners A..D of the back face, then of the front face
        for (int f = 0; f < 2; f++) begin
            v[f*4 + 0] = vertex_index(f, row, col, ny, nz);
            v[f*4 + 1] = vertex_index(f, row + 1, col, ny, nz);
            v[f*4 + 2] = vertex_index(f, row + 1, col + 1, ny, nz);
            v[f*4 + 3] = vertex_index(f, row, col + 1, ny, nz);
        end
        cell_left = 4 + 2 * (row == 0) + 2 * (row == ny - 1)
                      + 2 * (col == 0) + 2 * (col == nz - 1);
        emit_expected(v[V_BA], v[V_BC], v[V_BB], 1'b1, 1'b0, 1'b0);
        emit_expected(v[V_BA], v[V_BD], v[V_BC], 1'b1, 1'b0, 1'b1);
        emit_expected(v[V_FA], v[V_FB], v[V_FC], 1'b1, 1'b1, 1'b0);
        emit_expected(v[V_FA], v[V_FC], v[V_FD], 1'b1, 1'b1, 1'b1);
        // side walls: first row, last row, first column, last column
        if (row == 0) begin
            emit_expected(v[V_BA], v[V_FA], v[V_FD], 1'b0, 1'b0, 1'b0);
            emit_expected(v[V_BA], v[V_FD], v[V_BD], 1'b0, 1'b0, 1'b0);
        end
        if (row == ny - 1) begin
            emit_expected(v[V_BB], v[V_BC], v[V_FC], 1'b0, 1'b0, 1'b0);
            emit_expected(v[V_BB], v[V_FC], v[V_FB], 1'b0, 1'b0, 1'b0);
        end
        if (col == 0) begin
            emit_expected(v[V_BA], v[V_BB], v[V_FB], 1'b0, 1'b0, 1'b0);
            emit_expected(v[V_BA], v[V_FB], v[V_FA], 1'b0, 1'b0, 1'b0);
        end
        if (col == nz - 1) begin
            emit_expected(v[V_BD], v[V_FD], v[V_FC], 1'b0, 1'b0, 1'b0);
            emit_expected(v[V_BD], v[V_FC], v[V_BC], 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Request driver: predict on accept, then present the next queued cell
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                predict_cell_triangles(s_tdata[7:0], s_tdata[15:8], s_tuser[0]);
                cells_sent++;
            end
            if (!s_tvalid || o_s_tready) begin
                if (cells_pending.size() > 0 && (no_gaps || $urandom_range(99) >= 9)) begin
                    cell_req_t req;
                    req = cells_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {req.col, req.row};
                    s_tuser  <= req.first;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Result monitor: compare each accepted triangle with the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        triangle_t want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                triangles_seen++;
                if (triangles_due.size() == 0) begin
                    $error("triangle with no expectation: facet_number %0d",
                           o_m_tdata[18:0]);
                    err_count++;
                end else begin
                    want = triangles_due.pop_front();
                    check_field("facet_number", want.facet, o_m_tdata[18:0]);
                    check_field("vertex_a", want.va, o_m_tdata[36:19]);
                    check_field("vertex_b", want.vb, o_m_tdata[54:37]);
                    check_field("vertex_c", want.vc, o_m_tdata[72:55]);
                    check_field("is_tile", want.tile, o_m_tuser[0]);
                    check_field("tile_face", want.face, o_m_tuser[1]);
                    check_field("tile_half", want.half, o_m_tuser[2]);
                    check_field("last_of_cell", want.last, o_m_tlast);
                end
            end
            m_tready <= no_gaps || ($urandom_range(99) >= 9);
        end
    end

    // Write one configuration register and update the model copy
    task automatic write_reg(input t_cfg_idx idx, input logic [8:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_CELLS_Y) model_cells_y = value;
        else model_cells_z = value;
    endtask

    task automatic set_grid(input logic [8:0] y, input logic [8:0] z);
        write_reg(CFG_CELLS_Y, y);
        write_reg(CFG_CELLS_Z, z);
        grid_settings++;
    endtask

    task automatic queue_cell(input int row, input int col, input logic first);
        cells_pending.push_back('{row: ROW_W'(row), col: ROW_W'(col), first: first});
    endtask

    // Drain all requests and results, then cover the block's own latency
    task automatic settle();
        do @(posedge i_clk);
        while (cells_pending.size() != 0 || s_tvalid || triangles_due.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    // Favor the grid edges, where the wall triangles appear
    function automatic int pick_coord(input int n);
        if ($urandom_range(2) == 0) return $urandom_range(1) ? n - 1 : 0;
        return $urandom_range(n - 1);
    endfunction

    task automatic random_phase(input logic [8:0] y, input logic [8:0] z, input int count);
        int ny;
        int nz;
        set_grid(y, z);
        ny = grid_count(y, MAX_CELLS_Y);
        nz = grid_count(z, MAX_CELLS_Z);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 85)
                queue_cell(pick_coord(ny), pick_coord(nz), $urandom_range(99) < 8);
            else
                queue_cell($urandom_range(255), $urandom_range(255), $urandom_range(99) < 8);
        end
        settle();
    endtask

    // Stimulus sequence
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // reset grid of one cell; cells outside it, one of them clearing the counter
        queue_cell(0, 0, 1'b1);
        queue_cell(0, 0, 1'b0);
        queue_cell(1, 0, 1'b0);
        queue_cell(0, 5, 1'b0);
        queue_cell(255, 255, 1'b1);
        queue_cell(0, 0, 1'b0);
        settle();

        // zero counts fall back to one cell
        set_grid(9'd0, 9'd0);
        queue_cell(0, 0, 1'b0);
        queue_cell(0, 1, 1'b0);
        settle();

        // largest grid, corners and an inner cell
        set_grid(9'd256, 9'd256);
        queue_cell(0, 0, 1'b1);
        queue_cell(255, 255, 1'b0);
        queue_cell(0, 255, 1'b0);
        queue_cell(255, 0, 1'b0);
        queue_cell(128, 77, 1'b0);
        settle();

        // counts above the maximum saturate
        set_grid(9'd511, 9'd300);
        queue_cell(255, 255, 1'b0);
        queue_cell(255, 0, 1'b1);
        settle();

        // single row: both row walls on every cell inside the grid
        set_grid(9'd1, 9'd7);
        queue_cell(0, 3, 1'b0);
        queue_cell(0, 0, 1'b0);
        queue_cell(0, 6, 1'b0);
        queue_cell(0, 7, 1'b0);
        settle();

        // single column
        set_grid(9'd5, 9'd1);
        queue_cell(2, 0, 1'b0);
        queue_cell(4, 0, 1'b1);
        queue_cell(5, 0, 1'b0);
        settle();

        // random cells over several grids; one phase runs without any gaps
        random_phase(9'd4, 9'd6, 26);
        no_gaps = 1'b1;
        random_phase(9'd256, 9'd256, 26);
        no_gaps = 1'b0;
        random_phase(9'd2, 9'd200, 26);
        random_phase(9'($urandom_range(1, 16)), 9'($urandom_range(1, 16)), 26);
        random_phase(9'($urandom_range(511)), 9'($urandom_range(511)), 26);
        random_phase(9'd1, 9'd1, 26);

        if (triangles_due.size() != 0) begin
            $error("%0d expected triangles never arrived", triangles_due.size());
            err_count++;
        end
        $display("Sent %0d cell requests over %0d grid settings; checked %0d triangles.",
                 cells_sent, grid_settings, triangles_seen);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timeout waiting for the block");
        $display("testbench: errors");
        $finish;
    end

endmodule

[slab_mesh_facet_generator.f]
+incdir+hw/rtl
hw/rtl/smfg_pkg.sv
hw/rtl/smfg_vgen.sv
hw/rtl/slab_mesh_facet_generator.sv
tb/testbench.sv
